[design/rfmac_pkg.sv]
// Shared widths, codes and organization defaults for the RFM activation counter.
`timescale 1ns / 1ps
package rfmac_pkg;

    // Item field widths
    localparam int REQ_W     = 2;
    localparam int CH_W      = 3;
    localparam int PC_W      = 1;
    localparam int SID_W     = 1;
    localparam int RK_W      = 1;
    localparam int BG_W      = 2;
    localparam int BK_W      = 2;

    // Counter and configuration widths
    localparam int CNT_W     = 12;
    localparam int THR_W     = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Input request codes
    localparam logic [REQ_W-1:0] REQ_ACT    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RFM_PB = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RFM_AB = 2'd2;

    // Result request codes
    localparam logic [REQ_W-1:0] RFM_NONE   = 2'd0;
    localparam logic [REQ_W-1:0] RFM_PB     = 2'd1;
    localparam logic [REQ_W-1:0] RFM_AB     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RFM_ENABLE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_THRESHOLD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RFM_DECREMENT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALL_BANK_POLICY = 2'd3;

    // Organization defaults
    localparam int DEF_NUM_CHANNELS    = 8;
    localparam int DEF_NUM_PCHANS      = 2;
    localparam int DEF_NUM_STACK_IDS   = 1;
    localparam int DEF_NUM_RANKS       = 1;
    localparam int DEF_NUM_BANK_GROUPS = 4;
    localparam int DEF_BANKS_PER_BG    = 4;

endpackage

[design/rfmac_in_if.sv]
// Input channel: valid/ready handshake with the request beat payload.
`timescale 1ns / 1ps
interface rfmac_in_if;
    import rfmac_pkg::*;

    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [CH_W-1:0]  channel;
    logic [PC_W-1:0]  pchan;
    logic [SID_W-1:0] stack_id;
    logic [RK_W-1:0]  rank_in_channel;
    logic [BG_W-1:0]  bank_group;
    logic [BK_W-1:0]  bank;

    modport source (
        output valid, req_type, channel, pchan, stack_id,
               rank_in_channel, bank_group, bank,
        input  ready
    );

    modport sink (
        input  valid, req_type, channel, pchan, stack_id,
               rank_in_channel, bank_group, bank,
        output ready
    );
endinterface

[design/rfmac_out_if.sv]
// Output channel: valid/ready handshake with the RFM request beat payload.
`timescale 1ns / 1ps
interface rfmac_out_if;
    import rfmac_pkg::*;

    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] rfm_request;
    logic [CH_W-1:0]  out_channel;
    logic [PC_W-1:0]  out_pchan;
    logic [SID_W-1:0] out_stack_id;
    logic [RK_W-1:0]  out_rank;
    logic [BG_W-1:0]  out_bank_group;
    logic [BK_W-1:0]  out_bank;

    modport source (
        output valid, rfm_request, out_channel, out_pchan, out_stack_id,
               out_rank, out_bank_group, out_bank,
        input  ready
    );

    modport sink (
        input  valid, rfm_request, out_channel, out_pchan, out_stack_id,
               out_rank, out_bank_group, out_bank,
        output ready
    );
endinterface

[design/rfm_activation_counter_core.sv]
// RFM activation counter: per-bank counts and pending marks held in block memories.
//
//   port      | dir | handshake       | beat
//   ----------+-----+-----------------+--------------------------------------------
//   i_in      | in  | valid/ready     | req_type, rank coordinates, bank_group, bank
//   o_out     | out | valid/ready     | rfm_request and the coordinates it targets
//   i_cfg_*   | in  | write enable    | register index, data
//
// An activate or RFMpb beat first reads the bank's entry from the count memory,
// then updates it and writes it back. An RFMab beat walks the rank's banks one
// memory access per cycle, read and write-back overlapped, and then loads its
// result. After reset a clearing pass over all NUM_CHANNELS * NUM_PCHANS *
// NUM_STACK_IDS * NUM_RANKS * NUM_BANK_GROUPS * BANKS_PER_BG entries zeroes both
// memories; i_in.ready stays low during it.
// A result beat waits in the output register; the next input beat is still taken,
// and its update holds only if that register is still full when it is done.
`timescale 1ns / 1ps
module rfm_activation_counter_core #(
    parameter int NUM_CHANNELS    = rfmac_pkg::DEF_NUM_CHANNELS,
    parameter int NUM_PCHANS      = rfmac_pkg::DEF_NUM_PCHANS,
    parameter int NUM_STACK_IDS   = rfmac_pkg::DEF_NUM_STACK_IDS,
    parameter int NUM_RANKS       = rfmac_pkg::DEF_NUM_RANKS,
    parameter int NUM_BANK_GROUPS = rfmac_pkg::DEF_NUM_BANK_GROUPS,
    parameter int BANKS_PER_BG    = rfmac_pkg::DEF_BANKS_PER_BG
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rfmac_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rfmac_pkg::CFG_W-1:0]     i_cfg_data,
    rfmac_in_if.sink                       i_in,
    rfmac_out_if.source                    o_out
);
    import rfmac_pkg::*;

    localparam int TOTAL_RANKS   = NUM_CHANNELS * NUM_PCHANS * NUM_STACK_IDS
                                   * NUM_RANKS;
    localparam int BANKS_IN_RANK = NUM_BANK_GROUPS * BANKS_PER_BG;
    localparam int BANK_COUNT    = TOTAL_RANKS * BANKS_IN_RANK;
    localparam int AW            = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
    localparam int RW            = (TOTAL_RANKS > 1) ? $clog2(TOTAL_RANKS) : 1;
    localparam int WW            = $clog2(BANKS_IN_RANK + 1);
    localparam int EW            = CNT_W + 1;   // pending mark above the count

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_ALL,
        S_FIN
    } t_state;

    function automatic int clamp_idx(int v, int n);
        return (v >= n) ? n - 1 : v;
    endfunction

    function automatic logic [CNT_W-1:0] lower_cnt(logic [CNT_W-1:0] cnt,
                                                   logic [THR_W-1:0] dec);
        logic [CNT_W-1:0] d;
        d = CNT_W'(dec);
        return (cnt > d) ? cnt - d : '0;
    endfunction

    // Configuration registers
    logic             r_rfm_enable;
    logic [THR_W-1:0] r_act_threshold;
    logic [THR_W-1:0] r_rfm_decrement;
    logic             r_all_bank_policy;

    // Memories
    logic [EW-1:0] bank_mem [BANK_COUNT];
    logic          rank_mem [TOTAL_RANKS];
    logic [EW-1:0] r_rd_data;
    logic          r_rank_rd;

    // Control and latched beat
    t_state           r_state, n_state;
    logic [AW-1:0]    r_clr,   n_clr;
    logic [WW-1:0]    r_walk,  n_walk;
    logic [AW-1:0]    r_base;
    logic [AW-1:0]    r_flat;
    logic [RW-1:0]    r_rank;
    logic             r_bank_ok;
    logic [REQ_W-1:0] r_req_type;
    logic [CH_W-1:0]  r_channel;
    logic [PC_W-1:0]  r_pchan;
    logic [SID_W-1:0] r_stack_id;
    logic [RK_W-1:0]  r_rank_in_channel;
    logic [BG_W-1:0]  r_bank_group;
    logic [BK_W-1:0]  r_bank;

    // Output register
    logic             r_out_valid;
    logic [REQ_W-1:0] r_out_req;
    logic [CH_W-1:0]  r_out_channel;
    logic [PC_W-1:0]  r_out_pchan;
    logic [SID_W-1:0] r_out_stack_id;
    logic [RK_W-1:0]  r_out_rank;
    logic [BG_W-1:0]  r_out_bank_group;
    logic [BK_W-1:0]  r_out_bank;

    logic             w_accept;
    logic             w_out_free;
    logic [RW-1:0]    w_rank;
    logic [AW-1:0]    w_flat;
    logic             w_bank_ok;
    logic [THR_W-1:0] w_dec;

    logic             w_rd_en;
    logic [AW-1:0]    w_rd_addr;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [EW-1:0]    w_wdata;
    logic             w_rank_we;
    logic [RW-1:0]    w_rank_waddr;
    logic             w_rank_wdata;
    logic             w_out_load;
    logic [REQ_W-1:0] w_out_req;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;

    assign o_out.valid          = r_out_valid;
    assign o_out.rfm_request    = r_out_req;
    assign o_out.out_channel    = r_out_channel;
    assign o_out.out_pchan      = r_out_pchan;
    assign o_out.out_stack_id   = r_out_stack_id;
    assign o_out.out_rank       = r_out_rank;
    assign o_out.out_bank_group = r_out_bank_group;
    assign o_out.out_bank       = r_out_bank;

    // Rank and flat bank index of the incoming beat
    always_comb begin
        int c;
        int p;
        int s;
        int r;
        int rk;
        c  = clamp_idx(int'(i_in.channel), NUM_CHANNELS);
        p  = clamp_idx(int'(i_in.pchan), NUM_PCHANS);
        s  = clamp_idx(int'(i_in.stack_id), NUM_STACK_IDS);
        r  = clamp_idx(int'(i_in.rank_in_channel), NUM_RANKS);
        rk = ((c * NUM_PCHANS + p) * NUM_STACK_IDS + s) * NUM_RANKS + r;
        w_rank    = RW'(rk);
        w_flat    = AW'(rk * BANKS_IN_RANK + int'(i_in.bank_group) * BANKS_PER_BG
                        + int'(i_in.bank));
        w_bank_ok = (int'(i_in.bank_group) < NUM_BANK_GROUPS)
                    && (int'(i_in.bank) < BANKS_PER_BG);
    end

    assign w_dec = (r_rfm_decrement != '0) ? r_rfm_decrement :
                   (r_act_threshold != '0) ? r_act_threshold : THR_W'(1);

    // Read-modify-write sequencing
    always_comb begin
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] cnt_new;
        logic             pend;
        logic             pend_new;
        cnt      = r_rd_data[CNT_W-1:0];
        pend     = r_rd_data[CNT_W];
        cnt_new  = cnt;
        pend_new = pend;

        n_state      = r_state;
        n_clr        = r_clr;
        n_walk       = r_walk;
        w_rd_en      = 1'b0;
        w_rd_addr    = w_flat;
        w_we         = 1'b0;
        w_waddr      = r_flat;
        w_wdata      = '0;
        w_rank_we    = 1'b0;
        w_rank_waddr = r_rank;
        w_rank_wdata = 1'b0;
        w_out_load   = 1'b0;
        w_out_req    = RFM_NONE;

        case (r_state)
            S_CLEAR: begin
                w_we         = 1'b1;
                w_waddr      = r_clr;
                w_rank_we    = (int'(r_clr) < TOTAL_RANKS);
                w_rank_waddr = RW'(r_clr);
                n_clr        = r_clr + AW'(1);
                if (r_clr == AW'(BANK_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.req_type == REQ_RFM_AB) begin
                        n_walk  = '0;
                        n_state = S_ALL;
                    end else begin
                        w_rd_en = 1'b1;
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                // hold the update until the output register can take the result
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                    if (r_req_type == REQ_ACT) begin
                        if (r_rfm_enable && (r_act_threshold != '0) && r_bank_ok) begin
                            if (cnt < COUNT_MAX) begin
                                cnt_new = cnt + CNT_W'(1);
                            end
                            if (cnt_new >= CNT_W'(r_act_threshold)) begin
                                if (r_all_bank_policy) begin
                                    if (!r_rank_rd) begin
                                        w_rank_we    = 1'b1;
                                        w_rank_wdata = 1'b1;
                                        w_out_req    = RFM_AB;
                                    end
                                end else if (!pend) begin
                                    pend_new  = 1'b1;
                                    w_out_req = RFM_PB;
                                end
                            end
                            w_we    = 1'b1;
                            w_wdata = {pend_new, cnt_new};
                        end
                    end else if (r_req_type == REQ_RFM_PB) begin
                        if (r_bank_ok) begin
                            w_we    = 1'b1;
                            w_wdata = {1'b0, lower_cnt(cnt, w_dec)};
                        end
                    end
                end
            end
            S_ALL: begin
                // read one bank ahead, write back the one read last cycle
                w_rd_en   = (int'(r_walk) < BANKS_IN_RANK);
                w_rd_addr = r_base + AW'(r_walk);
                w_we      = (r_walk != '0);
                w_waddr   = r_base + AW'(r_walk) - AW'(1);
                w_wdata   = {1'b0, lower_cnt(cnt, w_dec)};
                n_walk    = r_walk + WW'(1);
                if (int'(r_walk) == BANKS_IN_RANK) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    w_rank_we  = 1'b1;
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Count memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            bank_mem[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rd_data <= bank_mem[w_rd_addr];
        end
    end

    // Rank pending memory
    always_ff @(posedge i_clk) begin
        if (w_rank_we) begin
            rank_mem[w_rank_waddr] <= w_rank_wdata;
        end
        if (w_accept) begin
            r_rank_rd <= rank_mem[w_rank];
        end
    end

    // State, configuration, latched beat and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_CLEAR;
            r_clr             <= '0;
            r_walk            <= '0;
            r_out_valid       <= 1'b0;
            r_rfm_enable      <= 1'b0;
            r_act_threshold   <= '0;
            r_rfm_decrement   <= '0;
            r_all_bank_policy <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_walk  <= n_walk;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RFM_ENABLE:      r_rfm_enable      <= i_cfg_data[0];
                    CFG_ACT_THRESHOLD:   r_act_threshold   <= THR_W'(i_cfg_data);
                    CFG_RFM_DECREMENT:   r_rfm_decrement   <= THR_W'(i_cfg_data);
                    CFG_ALL_BANK_POLICY: r_all_bank_policy <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (w_accept) begin
            r_req_type        <= i_in.req_type;
            r_channel         <= i_in.channel;
            r_pchan           <= i_in.pchan;
            r_stack_id        <= i_in.stack_id;
            r_rank_in_channel <= i_in.rank_in_channel;
            r_bank_group      <= i_in.bank_group;
            r_bank            <= i_in.bank;
            r_flat            <= w_flat;
            r_rank            <= w_rank;
            r_bank_ok         <= w_bank_ok;
            r_base            <= AW'(int'(w_rank) * BANKS_IN_RANK);
        end

        if (w_out_load) begin
            r_out_req <= w_out_req;
            if (w_out_req != RFM_NONE) begin
                r_out_channel    <= r_channel;
                r_out_pchan      <= r_pchan;
                r_out_stack_id   <= r_stack_id;
                r_out_rank       <= r_rank_in_channel;
                r_out_bank_group <= r_bank_group;
                r_out_bank       <= r_bank;
            end else begin
                r_out_channel    <= '0;
                r_out_pchan      <= '0;
                r_out_stack_id   <= '0;
                r_out_rank       <= '0;
                r_out_bank_group <= '0;
                r_out_bank       <= '0;
            end
        end
    end

endmodule
